// File: hdl/wqp_pkg.sv
// ----------------------------------------------------------------------------
// Windowed quota package
// Shared widths, codes and types of the windowed quota limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package wqp_pkg;

  localparam int unsigned UserSlotW   = 10;
  localparam int unsigned DomainSlotW = 8;
  localparam int unsigned CntW        = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CauseW      = 2;
  localparam int unsigned StepW       = 4;

  typedef logic [CauseW-1:0] cause_t;
  localparam cause_t CauseNone    = 2'd0;
  localparam cause_t CauseUserPen = 2'd1;
  localparam cause_t CauseDomPen  = 2'd2;
  localparam cause_t CauseLimit   = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUserEnable   = 3'd0,
    CfgUserWindow   = 3'd1,
    CfgUserLimit    = 3'd2,
    CfgUserPunish   = 3'd3,
    CfgDomainEnable = 3'd4,
    CfgDomainWindow = 3'd5,
    CfgDomainLimit  = 3'd6,
    CfgDomainPunish = 3'd7
  } cfg_idx_e;

  // One penalty box entry: a valid flag and the ticks still to serve.
  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] left;
  } pen_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_MOD    = 7'b0000100,
    S_REQ_RD = 7'b0001000,
    S_REQ_WR = 7'b0010000,
    S_TICK   = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  // Number of shift-subtract steps needed to reduce a w-bit slot index
  // modulo slots. Zero when every index is already in range.
  function automatic int unsigned red_steps(int unsigned slots, int unsigned w);
    int unsigned n;
    n = 0;
    for (int unsigned k = 0; k < 16; k++) begin
      if ((64'(slots) << k) < (64'(1) << w)) begin
        n++;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hdl/wqp_if.sv
// ----------------------------------------------------------------------------
// Windowed quota channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wqp_req_if import wqp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [UserSlotW-1:0]   user_slot;
  logic [DomainSlotW-1:0] domain_slot;
  logic                   has_domain;
  logic                   authenticated;
  logic                   exempt;

  modport source (
    output valid, op, user_slot, domain_slot, has_domain, authenticated, exempt,
    input  ready
  );
  modport sink (
    input  valid, op, user_slot, domain_slot, has_domain, authenticated, exempt,
    output ready
  );
endinterface

interface wqp_res_if import wqp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            verdict;
  logic [CauseW-1:0] cause;
  logic            user_over;
  logic            domain_over;
  logic [CntW-1:0] wait_ticks;

  modport source (
    output valid, verdict, cause, user_over, domain_over, wait_ticks,
    input  ready
  );
  modport sink (
    input  valid, verdict, cause, user_over, domain_over, wait_ticks,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/wqp_ram.sv
// ----------------------------------------------------------------------------
// Windowed quota RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wqp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output      logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// File: hdl/windowed_quota_with_penalty_unit.sv
// ----------------------------------------------------------------------------
// Windowed quota with penalty unit
// Two-level fixed-window rate limiter with a per-user and per-domain
// penalty box.
// ----------------------------------------------------------------------------
// In the default configuration a request item reads the user and domain
// counters and penalty entries from their RAMs (S_REQ_RD), then updates
// them and loads the result register (S_REQ_WR). When a slot count is not a
// power of two that covers the whole slot field, a shared shift-subtract
// unit first reduces the slot indices in up to ten steps (S_MOD). A tick
// item walks every table entry through the RAM ports, one entry per cycle.
// After reset the block runs a clearing pass that zeroes all tables; it
// accepts no item during that pass, though configuration writes are taken.
// The block holds one item at a time and is ready again as soon as the
// result is in the output register, so a new item may enter while that
// result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_quota_with_penalty_unit import wqp_pkg::*; #(
  parameter int unsigned USER_SLOTS   = 1024,
  parameter int unsigned DOMAIN_SLOTS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  wqp_req_if.sink                  req_i,
  wqp_res_if.source                res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned UAW       = $clog2(USER_SLOTS);
  localparam int unsigned DAW       = $clog2(DOMAIN_SLOTS);
  localparam int unsigned MaxSlots  = (USER_SLOTS > DOMAIN_SLOTS) ? USER_SLOTS : DOMAIN_SLOTS;
  localparam int unsigned IdxW      = $clog2(MaxSlots + 1);
  localparam int unsigned UserSteps = red_steps(USER_SLOTS, UserSlotW);
  localparam int unsigned DomSteps  = red_steps(DOMAIN_SLOTS, DomainSlotW);
  localparam int unsigned ModSteps  = (UserSteps > DomSteps) ? UserSteps : DomSteps;
  localparam int unsigned PenW      = CntW + 1;

  // Sequencer and item registers.
  state_e                 state_q, state_d;
  logic [UserSlotW-1:0]   us_q, us_d;
  logic [DomainSlotW-1:0] ds_q, ds_d;
  logic                   hd_q, auth_q, ex_q;
  logic [StepW-1:0]       step_q, step_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        sw_idx_q;
  logic                   sw_pend_q;
  logic                   uclr_q, dclr_q;

  // Configuration and window registers.
  logic            ue_q, de_q;
  logic [CntW-1:0] uwin_q, ulim_q, upun_q, dwin_q, dlim_q, dpun_q;
  logic [CntW-1:0] uwl_q, dwl_q;

  // Result register.
  logic            out_valid_q;
  logic            verdict_q, uo_q, dov_q;
  cause_t          cause_q;
  logic [CntW-1:0] wait_q;

  // RAM ports.
  logic            ucnt_we, upen_we, dcnt_we, dpen_we;
  logic [UAW-1:0]  u_wa, u_ra;
  logic [DAW-1:0]  d_wa, d_ra;
  logic [CntW-1:0] ucnt_wd, dcnt_wd, ucnt_rd, dcnt_rd;
  pen_t            upen_wd, dpen_wd, upen_rd, dpen_rd;

  logic accept, go;
  assign accept = req_i.valid && req_i.ready;
  assign go     = !out_valid_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // --------------------------------------------------------------------------
  // Request decision, evaluated while the RAM read data is present.
  // --------------------------------------------------------------------------
  logic            active, blk_u, blk_d, bump, uo, dov, r_verdict;
  logic [CntW-1:0] ucnt_inc, dcnt_inc, r_wait;
  cause_t          r_cause;

  always_comb begin
    ucnt_inc = (ucnt_rd == '1) ? ucnt_rd : ucnt_rd + 1'b1;
    dcnt_inc = (dcnt_rd == '1) ? dcnt_rd : dcnt_rd + 1'b1;
    active   = (ue_q || de_q) && auth_q && !ex_q;
    blk_u    = active && upen_rd.valid;
    blk_d    = active && !blk_u && hd_q && dpen_rd.valid;
    bump     = active && !blk_u && !blk_d;
    uo       = bump && ue_q && (ucnt_inc > ulim_q);
    dov      = bump && de_q && hd_q && (dcnt_inc > dlim_q);
    r_verdict = blk_u || blk_d || uo || dov;
    if (blk_u) begin
      r_cause = CauseUserPen;
      r_wait  = upen_rd.left;
    end else if (blk_d) begin
      r_cause = CauseDomPen;
      r_wait  = dpen_rd.left;
    end else if (uo) begin
      r_cause = CauseLimit;
      r_wait  = upun_q;
    end else if (dov) begin
      r_cause = CauseLimit;
      r_wait  = dpun_q;
    end else begin
      r_cause = CauseNone;
      r_wait  = '0;
    end
  end

  // Penalty aging for the entries coming back during a tick sweep.
  function automatic pen_t age(pen_t p);
    pen_t r;
    r = p;
    if (p.left <= CntW'(1)) begin
      r = '0;
    end else begin
      r.left = p.left - 1'b1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // RAM write and read port steering.
  // --------------------------------------------------------------------------
  logic sw_u_in, sw_d_in, cl_u_in, cl_d_in;
  assign sw_u_in = sw_pend_q && (sw_idx_q < IdxW'(USER_SLOTS));
  assign sw_d_in = sw_pend_q && (sw_idx_q < IdxW'(DOMAIN_SLOTS));
  assign cl_u_in = idx_q < IdxW'(USER_SLOTS);
  assign cl_d_in = idx_q < IdxW'(DOMAIN_SLOTS);

  always_comb begin
    ucnt_we = 1'b0;
    upen_we = 1'b0;
    dcnt_we = 1'b0;
    dpen_we = 1'b0;
    u_wa    = UAW'(us_q);
    d_wa    = DAW'(ds_q);
    u_ra    = UAW'(us_q);
    d_ra    = DAW'(ds_q);
    ucnt_wd = ucnt_inc;
    dcnt_wd = dcnt_inc;
    upen_wd = '{valid: 1'b1, left: upun_q};
    dpen_wd = '{valid: 1'b1, left: dpun_q};
    unique case (state_q)
      S_CLEAR: begin
        u_wa    = UAW'(idx_q);
        d_wa    = DAW'(idx_q);
        ucnt_we = cl_u_in;
        upen_we = cl_u_in;
        dcnt_we = cl_d_in;
        dpen_we = cl_d_in;
        ucnt_wd = '0;
        dcnt_wd = '0;
        upen_wd = '0;
        dpen_wd = '0;
      end
      S_TICK: begin
        u_ra    = UAW'(idx_q);
        d_ra    = DAW'(idx_q);
        u_wa    = UAW'(sw_idx_q);
        d_wa    = DAW'(sw_idx_q);
        ucnt_we = sw_u_in && uclr_q;
        dcnt_we = sw_d_in && dclr_q;
        upen_we = sw_u_in && upen_rd.valid;
        dpen_we = sw_d_in && dpen_rd.valid;
        ucnt_wd = '0;
        dcnt_wd = '0;
        upen_wd = age(upen_rd);
        dpen_wd = age(dpen_rd);
      end
      S_REQ_WR: begin
        ucnt_we = go && bump && ue_q;
        dcnt_we = go && bump && de_q && hd_q;
        upen_we = go && uo;
        dpen_we = go && dov;
      end
      default: begin
      end
    endcase
  end

  logic [PenW-1:0] upen_rd_raw, dpen_rd_raw;
  assign upen_rd = pen_t'(upen_rd_raw);
  assign dpen_rd = pen_t'(dpen_rd_raw);

  wqp_ram #(.Width(CntW), .Depth(USER_SLOTS)) u_ucnt_ram (
    .clk_i, .wr_en_i(ucnt_we), .wr_addr_i(u_wa), .wr_data_i(ucnt_wd),
    .rd_addr_i(u_ra), .rd_data_o(ucnt_rd)
  );
  wqp_ram #(.Width(PenW), .Depth(USER_SLOTS)) u_upen_ram (
    .clk_i, .wr_en_i(upen_we), .wr_addr_i(u_wa), .wr_data_i(PenW'(upen_wd)),
    .rd_addr_i(u_ra), .rd_data_o(upen_rd_raw)
  );
  wqp_ram #(.Width(CntW), .Depth(DOMAIN_SLOTS)) u_dcnt_ram (
    .clk_i, .wr_en_i(dcnt_we), .wr_addr_i(d_wa), .wr_data_i(dcnt_wd),
    .rd_addr_i(d_ra), .rd_data_o(dcnt_rd)
  );
  wqp_ram #(.Width(PenW), .Depth(DOMAIN_SLOTS)) u_dpen_ram (
    .clk_i, .wr_en_i(dpen_we), .wr_addr_i(d_wa), .wr_data_i(PenW'(dpen_wd)),
    .rd_addr_i(d_ra), .rd_data_o(dpen_rd_raw)
  );

  // --------------------------------------------------------------------------
  // Shared shift-subtract step that reduces the slot indices.
  // --------------------------------------------------------------------------
  logic [31:0] usub, dsub;
  assign usub = 32'(USER_SLOTS) << step_q;
  assign dsub = 32'(DOMAIN_SLOTS) << step_q;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    us_d    = us_q;
    ds_d    = ds_q;
    step_d  = step_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_CLEAR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(MaxSlots - 1)) begin
          state_d = S_IDLE;
          idx_d   = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (req_i.op) begin
            state_d = S_TICK;
          end else begin
            us_d   = req_i.user_slot;
            ds_d   = req_i.domain_slot;
            step_d = StepW'(ModSteps - 1);
            state_d = (ModSteps > 0) ? S_MOD : S_REQ_RD;
          end
        end
      end
      S_MOD: begin
        if (32'(us_q) >= usub) begin
          us_d = us_q - UserSlotW'(usub);
        end
        if (32'(ds_q) >= dsub) begin
          ds_d = ds_q - DomainSlotW'(dsub);
        end
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = S_REQ_RD;
        end
      end
      S_REQ_RD: begin
        state_d = S_REQ_WR;
      end
      S_REQ_WR: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      S_TICK: begin
        if (idx_q == IdxW'(MaxSlots)) begin
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      step_q    <= '0;
      sw_pend_q <= 1'b0;
      sw_idx_q  <= '0;
      uclr_q    <= 1'b0;
      dclr_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      step_q    <= step_d;
      sw_pend_q <= (state_q == S_TICK) && (idx_q < IdxW'(MaxSlots));
      sw_idx_q  <= idx_q;
      if (accept && req_i.op) begin
        uclr_q <= ue_q && (uwl_q <= CntW'(1));
        dclr_q <= de_q && (dwl_q <= CntW'(1));
      end
    end
  end

  // Item payload needs no reset.
  always_ff @(posedge clk_i) begin
    us_q <= us_d;
    ds_q <= ds_d;
    if (accept) begin
      hd_q   <= req_i.has_domain;
      auth_q <= req_i.authenticated;
      ex_q   <= req_i.exempt;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers and window countdowns. A window write reloads
  // its countdown; a tick at an enabled level either decrements it or, when it
  // runs out, reloads it and has the sweep clear that level's counters.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ue_q   <= 1'b0;
      uwin_q <= CntW'(5);
      ulim_q <= CntW'(50);
      upun_q <= CntW'(33);
      de_q   <= 1'b0;
      dwin_q <= CntW'(10);
      dlim_q <= CntW'(100);
      dpun_q <= CntW'(66);
      uwl_q  <= '0;
      dwl_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgUserEnable:   ue_q <= cfg_wdata_i[0];
        CfgUserWindow: begin
          uwin_q <= cfg_wdata_i;
          uwl_q  <= cfg_wdata_i;
        end
        CfgUserLimit:    ulim_q <= cfg_wdata_i;
        CfgUserPunish:   upun_q <= cfg_wdata_i;
        CfgDomainEnable: de_q <= cfg_wdata_i[0];
        CfgDomainWindow: begin
          dwin_q <= cfg_wdata_i;
          dwl_q  <= cfg_wdata_i;
        end
        CfgDomainLimit:  dlim_q <= cfg_wdata_i;
        CfgDomainPunish: dpun_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end else if (accept && req_i.op) begin
      if (ue_q) begin
        uwl_q <= (uwl_q <= CntW'(1)) ? uwin_q : uwl_q - 1'b1;
      end
      if (de_q) begin
        dwl_q <= (dwl_q <= CntW'(1)) ? dwin_q : dwl_q - 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register. A tick item yields an all-zero result.
  // --------------------------------------------------------------------------
  logic load_req, load_tick;
  assign load_req  = (state_q == S_REQ_WR) && go;
  assign load_tick = (state_q == S_FIN) && go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_req || load_tick) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_req) begin
      verdict_q <= r_verdict;
      cause_q   <= r_cause;
      uo_q      <= uo;
      dov_q     <= dov;
      wait_q    <= r_wait;
    end else if (load_tick) begin
      verdict_q <= 1'b0;
      cause_q   <= CauseNone;
      uo_q      <= 1'b0;
      dov_q     <= 1'b0;
      wait_q    <= '0;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.verdict     = verdict_q;
  assign res_o.cause       = cause_q;
  assign res_o.user_over   = uo_q;
  assign res_o.domain_over = dov_q;
  assign res_o.wait_ticks  = wait_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_limit_has_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.cause == CauseLimit) |-> res_o.user_over || res_o.domain_over)
    else $error("limit cause without an over flag");

  a_pass_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.verdict |->
      (res_o.cause == CauseNone) && (res_o.wait_ticks == '0) &&
      !res_o.user_over && !res_o.domain_over)
    else $error("passed item carries reject fields");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK) |-> (idx_q <= IdxW'(MaxSlots)))
    else $error("tick sweep index out of range");

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |=> out_valid_q && $stable(wait_q) && $stable(cause_q))
    else $error("pending result overwritten");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(ucnt_we || upen_we || dcnt_we || dpen_we))
    else $error("table written while idle");

endmodule

`default_nettype wire
